// ----- design/tsrdz_pkg.sv -----
package tsrdz_pkg;

	localparam logic [14:0] FULL_SCALE = 15'h7fff;
	localparam logic [14:0] DZ_RESET = 15'd7849;

	typedef struct packed {
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
	} in_item_t;

	typedef struct packed {
		logic [14:0] norm_magnitude;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic in_dead_zone;
	} out_item_t;

	typedef struct packed {
		logic [31:0] v;
		logic [31:0] res;
	} sqrt_t;

	typedef struct packed {
		logic q;
		logic [30:0] rem;
	} div_t;

	// one digit of the bit-pair square root
	function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [31:0] bitv);
		sqrt_t nxt;
		logic [32:0] trial;
		trial = {1'b0, cur.res} + {1'b0, bitv};
		if ({1'b0, cur.v} >= trial) begin
			nxt.v = cur.v - trial[31:0];
			nxt.res = (cur.res >> 1) + bitv;
		end else begin
			nxt.v = cur.v;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	// one quotient bit of restoring division at position sh
	function automatic div_t div_step(input logic [30:0] rem, input logic [15:0] d,
			input logic [3:0] sh);
		div_t o;
		logic [47:0] trial;
		trial = {17'b0, rem} - ({32'b0, d} << sh);
		if (!trial[47]) begin
			o.q = 1'b1;
			o.rem = trial[30:0];
		end else begin
			o.q = 1'b0;
			o.rem = rem;
		end
		return o;
	endfunction

endpackage

// ----- design/thumbstick_radial_dead_zone_top.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (stick_x, stick_y)
// out     | output    | out_valid / out_ready| out_data (norm_magnitude, norm_x, norm_y,
//         |           |                      |           in_dead_zone)
// cfg     | input     | cfg_we               | cfg_wdata (dead_zone)
//
// One item enters per cycle while the output is not blocked. The pipeline is built on
// three digit-serial units: a 16-digit square root, a 15-bit restoring magnitude
// divider and a 15-bit restoring axis divider pair, up to two digits per stage.
// Reset clears the valid bits and loads the dead zone with 7849.
// A stall at the output freezes every stage at once; bubbles drain forward when the
// output is free, so nothing is lost or repeated.
module thumbstick_radial_dead_zone_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tsrdz_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tsrdz_pkg::out_item_t  out_data,
	input  logic                  cfg_we,
	input  logic [14:0]           cfg_wdata
);
	import tsrdz_pkg::*;

	// stage map
	localparam int SQ0 = 1;   // square root, stages 1..8
	localparam int PRE = 9;   // radius known, dead zone test, rescale numerator
	localparam int MD0 = 10;  // magnitude divide, stages 10..17
	localparam int AXM = 18;  // axis products
	localparam int AD0 = 19;  // axis divides, stages 19..26
	localparam int FIN = 27;  // sign and pack
	localparam int NST = 28;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		sqrt_t sq;
		logic [15:0] r;
		logic in_zone;
		logic [14:0] den;
		logic [30:0] mrem;
		logic [14:0] mq;
		logic [14:0] mag;
		logic [30:0] xrem;
		logic [14:0] xq;
		logic [30:0] yrem;
		logic [14:0] yq;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
	} pipe_t;

	logic [14:0] dz_q;
	logic adv;
	logic vld_s [NST];
	pipe_t pipe_s [NST];
	pipe_t nxt [NST];

	// advance the whole pipe unless a finished item is blocked
	assign adv = !vld_s[NST-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
		end else if (cfg_we) begin
			dz_q <= cfg_wdata;
		end
	end

	genvar s;
	generate
		for (s = 0; s < NST; s++) begin : g_stage
			always_comb begin
				logic [15:0] ax;
				logic [15:0] ay;
				logic [15:0] clip;
				logic [14:0] m;
				div_t dx;
				div_t dy;
				if (s == 0) begin
					nxt[s] = '0;
					nxt[s].sx = in_data.stick_x;
					nxt[s].sy = in_data.stick_y;
					nxt[s].sq.v = 32'(in_data.stick_x * in_data.stick_x)
						+ 32'(in_data.stick_y * in_data.stick_y);
					nxt[s].sq.res = '0;
				end else begin
					nxt[s] = pipe_s[(s == 0) ? 0 : s-1];
				end
				ax = (nxt[s].sx < 0) ? 16'(-nxt[s].sx) : 16'(nxt[s].sx);
				ay = (nxt[s].sy < 0) ? 16'(-nxt[s].sy) : 16'(nxt[s].sy);
				clip = '0;
				m = '0;
				dx = '0;
				dy = '0;
				if (s >= SQ0 && s < PRE) begin
					// two root digits per stage
					nxt[s].sq = sqrt_step(nxt[s].sq, 32'(1) << (30 - 4*(s-SQ0)));
					nxt[s].sq = sqrt_step(nxt[s].sq, 32'(1) << (28 - 4*(s-SQ0)));
				end
				if (s == PRE) begin
					nxt[s].r = nxt[s].sq.res[15:0];
					nxt[s].in_zone = (nxt[s].r <= {1'b0, dz_q});
					clip = (nxt[s].r > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : nxt[s].r;
					m = clip[14:0] - dz_q;
					// m * 32767 as a shift and subtract
					nxt[s].mrem = ({16'b0, m} << 15) - {16'b0, m};
					nxt[s].den = FULL_SCALE - dz_q;
					nxt[s].mq = '0;
				end
				if (s >= MD0 && s < AXM) begin
					dx = div_step(nxt[s].mrem, {1'b0, nxt[s].den}, 4'(14 - 2*(s-MD0)));
					nxt[s].mrem = dx.rem;
					nxt[s].mq = {nxt[s].mq[13:0], dx.q};
					if (14 - 2*(s-MD0) > 0) begin
						dx = div_step(nxt[s].mrem, {1'b0, nxt[s].den}, 4'(13 - 2*(s-MD0)));
						nxt[s].mrem = dx.rem;
						nxt[s].mq = {nxt[s].mq[13:0], dx.q};
					end
				end
				if (s == AXM) begin
					nxt[s].mag = (nxt[s].den == '0) ? FULL_SCALE : nxt[s].mq;
					nxt[s].xrem = 31'(nxt[s].mag * ax);
					nxt[s].yrem = 31'(nxt[s].mag * ay);
					nxt[s].xq = '0;
					nxt[s].yq = '0;
				end
				if (s >= AD0 && s < FIN) begin
					dx = div_step(nxt[s].xrem, nxt[s].r, 4'(14 - 2*(s-AD0)));
					dy = div_step(nxt[s].yrem, nxt[s].r, 4'(14 - 2*(s-AD0)));
					nxt[s].xrem = dx.rem;
					nxt[s].yrem = dy.rem;
					nxt[s].xq = {nxt[s].xq[13:0], dx.q};
					nxt[s].yq = {nxt[s].yq[13:0], dy.q};
					if (14 - 2*(s-AD0) > 0) begin
						dx = div_step(nxt[s].xrem, nxt[s].r, 4'(13 - 2*(s-AD0)));
						dy = div_step(nxt[s].yrem, nxt[s].r, 4'(13 - 2*(s-AD0)));
						nxt[s].xrem = dx.rem;
						nxt[s].yrem = dy.rem;
						nxt[s].xq = {nxt[s].xq[13:0], dx.q};
						nxt[s].yq = {nxt[s].yq[13:0], dy.q};
					end
				end
				if (s == FIN) begin
					// restore signs; zero everything inside the dead zone
					if (nxt[s].in_zone) begin
						nxt[s].mag = '0;
						nxt[s].nx = '0;
						nxt[s].ny = '0;
					end else begin
						nxt[s].nx = (nxt[s].sx < 0) ? -$signed({1'b0, nxt[s].xq})
							: $signed({1'b0, nxt[s].xq});
						nxt[s].ny = (nxt[s].sy < 0) ? -$signed({1'b0, nxt[s].yq})
							: $signed({1'b0, nxt[s].yq});
					end
				end
			end

			// payload holds on stall, no reset needed
			always_ff @(posedge clk) begin
				if (adv) begin
					pipe_s[s] <= nxt[s];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[s] <= 1'b0;
				end else if (adv) begin
					vld_s[s] <= (s == 0) ? in_valid : vld_s[(s == 0) ? 0 : s-1];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NST-1];
	assign out_data.norm_magnitude = pipe_s[NST-1].mag;
	assign out_data.norm_x = pipe_s[NST-1].nx;
	assign out_data.norm_y = pipe_s[NST-1].ny;
	assign out_data.in_dead_zone = pipe_s[NST-1].in_zone;

endmodule

// ----- design/tsrdz_checker.sv -----
module tsrdz_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input tsrdz_pkg::out_item_t  out_data
);
	import tsrdz_pkg::*;

	// hold a blocked item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_dead_zone |->
		out_data.norm_magnitude == '0 && out_data.norm_x == '0 && out_data.norm_y == '0)
		else $error("nonzero output inside dead zone");

	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_dead_zone |-> out_data.norm_magnitude != '0)
		else $error("zero magnitude outside dead zone");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.norm_x != 16'sh8000 && out_data.norm_y != 16'sh8000)
		else $error("axis beyond full scale");

endmodule

bind thumbstick_radial_dead_zone_top tsrdz_checker u_tsrdz_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
